// ----- src/agf_pkg.sv -----
// ----------------------------------------------------------------------------
// agf_pkg: shared types and constants for the address map gap finder
// Character codes, register indexes, reset values and the beat types that
// pass between the input stage, the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package agf_pkg;

	// address and window width
	localparam int ADDR_BITS_DEF = 64;
	localparam int WIN_W         = 64;

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 1'b1;

	// register reset values
	localparam logic [WIN_W-1:0] WINDOW_LOW_RESET  = 64'h0000_0000_0001_0000;
	localparam logic [WIN_W-1:0] WINDOW_HIGH_RESET = 64'h0000_7FFF_FFFF_F000;

	// listing characters
	localparam logic [7:0] CHAR_DASH    = 8'h2D;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_NINE    = 8'h39;

	// one listing beat
	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_listing;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [WIN_W-1:0] gap_base;
		logic [WIN_W-1:0] gap_length;
		logic             final_gap;
		logic             malformed;
	} result_t;

	// low nibble of a hex digit: '0'..'9' map directly, anything above '9'
	// counts from 'a' = 10, which in the low nibble is code + 9
	function automatic logic [3:0] hex_nibble(input logic [7:0] code);
		logic [3:0] nib;
		if (code <= CHAR_NINE) begin
			nib = code[3:0];
		end else begin
			nib = code[3:0] + 4'd9;
		end
		return nib;
	endfunction

endpackage

`default_nettype wire

// ----- src/agf_in_stage.sv -----
// ----------------------------------------------------------------------------
// agf_in_stage: input register
// Holds one listing beat for the parser; refills in the same cycle the held
// beat is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module agf_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire agf_pkg::item_t s_item,
	input  wire logic           can_load,   // output stage has room
	output logic                valid_s1,
	output agf_pkg::item_t      item_s1
);

	logic accept;

	// room when empty or when the held beat moves on this cycle
	assign s_tready = !valid_s1 || can_load;
	assign accept   = s_tvalid && s_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (can_load) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= s_item;
		end
	end

endmodule

`default_nettype wire

// ----- src/agf_parse.sv -----
// ----------------------------------------------------------------------------
// agf_parse: line parser and gap computation
// Keeps the parse phase, the two address accumulators and the window
// registers; judges one beat per cycle while the beat in s1 advances and produces at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module agf_parse #(
	parameter int ADDR_BITS = agf_pkg::ADDR_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [agf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [agf_pkg::WIN_W-1:0]     cfg_wdata,
	input  wire logic                          advance,   // beat in s1 consumed
	input  wire agf_pkg::item_t                item_s1,
	output logic                               res_valid,
	output agf_pkg::result_t                   res
);

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_FINISH = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;

	logic [1:0]                  phase_q, phase_d;
	logic [ADDR_BITS-1:0]        start_acc_q, start_acc_d;
	logic [ADDR_BITS-1:0]        fin_acc_q, fin_acc_d;
	logic [agf_pkg::WIN_W-1:0]   win_low_q, win_high_q;
	logic [agf_pkg::WIN_W-1:0]   start_ext, fin_ext, lo, hi_mid, hi;
	logic [3:0]                  nib;
	logic                        gap_ok;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_low_q  <= agf_pkg::WINDOW_LOW_RESET;
			win_high_q <= agf_pkg::WINDOW_HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				agf_pkg::REG_WINDOW_LOW:  win_low_q  <= cfg_wdata;
				agf_pkg::REG_WINDOW_HIGH: win_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clipped gap: previous end up to this start, or to the window top at end
	assign start_ext = agf_pkg::WIN_W'(start_acc_q);
	assign fin_ext   = agf_pkg::WIN_W'(fin_acc_q);
	assign lo        = (fin_ext > win_low_q) ? fin_ext : win_low_q;
	assign hi_mid    = (start_ext < win_high_q) ? start_ext : win_high_q;
	assign hi        = item_s1.end_of_listing ? win_high_q : hi_mid;
	assign gap_ok    = hi > lo;
	assign nib       = agf_pkg::hex_nibble(item_s1.char_code);

	// next state and result for the beat in s1
	always_comb begin
		phase_d        = phase_q;
		start_acc_d    = start_acc_q;
		fin_acc_d      = fin_acc_q;
		res_valid      = 1'b0;
		res.gap_base   = lo;
		res.gap_length = hi - lo;
		res.final_gap  = 1'b0;
		res.malformed  = 1'b0;
		if (item_s1.end_of_listing) begin
			res.final_gap = 1'b1;
			if (phase_q == PH_START) begin
				res_valid = gap_ok;
			end else begin
				// listing cut off mid-line
				res_valid      = 1'b1;
				res.malformed  = 1'b1;
				res.gap_base   = '0;
				res.gap_length = '0;
			end
			phase_d     = PH_START;
			start_acc_d = '0;
			fin_acc_d   = '0;
		end else begin
			case (phase_q)
				PH_START: begin
					if (item_s1.char_code == agf_pkg::CHAR_DASH) begin
						res_valid   = gap_ok;
						start_acc_d = '0;
						fin_acc_d   = '0;
						phase_d     = PH_FINISH;
					end else begin
						start_acc_d = {start_acc_q[ADDR_BITS-5:0], nib};
					end
				end
				PH_FINISH: begin
					if (item_s1.char_code == agf_pkg::CHAR_SPACE) begin
						phase_d = PH_SKIP;
					end else begin
						fin_acc_d = {fin_acc_q[ADDR_BITS-5:0], nib};
					end
				end
				default: begin
					// rest of line
					if (item_s1.char_code == agf_pkg::CHAR_NEWLINE) begin
						phase_d = PH_START;
					end
				end
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			start_acc_q <= '0;
			fin_acc_q   <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			start_acc_q <= start_acc_d;
			fin_acc_q   <= fin_acc_d;
		end
	end

	// end of listing always leaves the parser in its reset state
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_listing |=>
			phase_q == PH_START && start_acc_q == '0 && fin_acc_q == '0)
		else $error("parser not cleared after end of listing");

	// a dash in the start field moves to the end field with cleared accumulators
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_s1.end_of_listing && phase_q == PH_START &&
			item_s1.char_code == agf_pkg::CHAR_DASH |=>
			phase_q == PH_FINISH && start_acc_q == '0 && fin_acc_q == '0)
		else $error("dash did not start the end field");

	// a mid-listing result is a real gap inside the window
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.final_gap |->
			res.gap_length != '0 && res.gap_base >= win_low_q &&
			!res.malformed)
		else $error("bad mid-listing gap");

endmodule

`default_nettype wire

// ----- src/agf_out_stage.sv -----
// ----------------------------------------------------------------------------
// agf_out_stage: result register
// Holds one result beat until the receiver takes it; accepts a new one in
// the same cycle the held beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module agf_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,      // new result from the parser
	input  wire agf_pkg::result_t res,
	output logic                  can_load,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output agf_pkg::result_t      res_q
);

	logic valid_q;

	assign can_load = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= push;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	// a result only arrives when there is room for it
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> can_load)
		else $error("result pushed into a full output register");

	// a held, untaken result survives to the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !m_tready |=> valid_q && $stable(res_q))
		else $error("held result lost");

endmodule

`default_nettype wire

// ----- src/address_map_gap_finder_top.sv -----
// ----------------------------------------------------------------------------
// address_map_gap_finder_top: free gaps of a memory-map listing
// Parses a listing one character per beat and reports the free gaps between
// mapped regions, clipped to a programmable address window.
//
// Input stream (s_*): one character per beat in s_tdata[7:0]; s_tlast marks
//   the end of the listing, and then the character is ignored.
// Output stream (m_*): at most one result per input beat; m_tdata carries the
//   gap base and length, m_tlast marks the result of the end-of-listing beat, and
//   m_tuser flags a listing that ended mid-line (gap fields are then zero).
// Config port: cfg_we / cfg_index / cfg_wdata write window_low (index 0)
//   and window_high (index 1), one register per write; write only while idle.
// Throughput: one beat per cycle while the result side is not stalled; the
//   parse step (one 64-bit max, min, compare and subtract) lies between the
//   input and result registers.
// Result path: an accepted beat waits in the input register, and its result
//   is then held in the result register.
// Reset: parser returns to the start field with cleared accumulators; the
//   window takes 0x10000 .. 0x7FFFFFFFF000. No clearing pass.
// Stall: a held result blocks the input only when the input register is
//   also full; then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module address_map_gap_finder_top #(
	parameter int ADDR_BITS = agf_pkg::ADDR_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// listing stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // [7:0] char_code
	input  wire logic                          s_tlast,   // end_of_listing
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [127:0]                       m_tdata,   // [63:0] gap_base, [127:64] gap_length
	output logic                               m_tlast,   // final_gap
	output logic [0:0]                         m_tuser,   // [0] malformed
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [agf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [agf_pkg::WIN_W-1:0]     cfg_wdata
);

	agf_pkg::item_t   s_item, item_s1;
	agf_pkg::result_t res, res_q;
	logic             valid_s1, can_load, advance, res_valid;

	assign s_item.char_code      = s_tdata;
	assign s_item.end_of_listing = s_tlast;
	assign advance               = valid_s1 && can_load;

	agf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.can_load (can_load),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	agf_parse #(
		.ADDR_BITS (ADDR_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	agf_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance && res_valid),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res_q    (res_q)
	);

	// result beat packing
	assign m_tdata = {res_q.gap_length, res_q.gap_base};
	assign m_tlast = res_q.final_gap;
	assign m_tuser = res_q.malformed;

endmodule

`default_nettype wire

// ----- sim/address_map_gap_finder_top_test.sv -----
// ----------------------------------------------------------------------------
// address_map_gap_finder_top_test: self-checking bench for the gap finder
// Streams memory-map listings into the block one character per beat and
// checks every reported gap against a cycle-free model of the parser or, for
// pinned rows, a hand-worked result. A short table of hand-picked beats comes
// first, then random listings under several address windows, with bursty
// input and a stalling result side.
module address_map_gap_finder_top_test;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_BEATS   = 850;
	localparam int PHASE_COUNT    = 6;
	localparam int MAX_REPORTS    = 30;
	localparam int DRAIN_CYCLES   = 4;
	localparam logic [7:0] CHAR_ZERO    = "0";
	localparam logic [7:0] CHAR_LOWER_A = "a";
	localparam logic [7:0] CHAR_UPPER_A = "A";
	localparam logic [7:0] CHAR_JUNK    = "x";

	typedef enum logic [1:0] {SCAN_START, SCAN_FINISH, SCAN_SKIP} scan_phase_t;
	typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_LONG} ready_mode_t;

	// one row of the directed table; pinned rows carry a hand-worked result
	typedef struct {
		logic [7:0]       ch;
		logic             eol;
		bit               pinned;
		bit               hit;
		agf_pkg::result_t gap;
	} probe_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;    // [7:0] char_code
	logic         s_tlast;    // end_of_listing
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;    // [63:0] gap_base, [127:64] gap_length
	logic         m_tlast;    // final_gap
	logic [0:0]   m_tuser;    // [0] malformed
	logic         cfg_we;
	logic [agf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [agf_pkg::WIN_W-1:0]     cfg_wdata;

	// hand-worked result travelling alongside the beat that causes it
	logic             pin_valid;
	logic             pin_hit;
	agf_pkg::result_t pin_gap;

	// parser model state
	logic [agf_pkg::WIN_W-1:0] win_low;
	logic [agf_pkg::WIN_W-1:0] win_high;
	scan_phase_t               scan_phase;
	logic [63:0]               start_addr;
	logic [63:0]               finish_addr;

	agf_pkg::result_t expected_gaps[$];
	int      mismatch_count;
	int      beats_accepted;
	int      gaps_predicted;
	int      gaps_checked;
	int      malformed_seen;
	int      windows_used;
	int      listings_sent;

	// source and sink pacing
	int          gap_max;
	int          burst_left;
	ready_mode_t ready_mode;
	int          stall_left;
	logic [3:0]  pattern_step;

	probe_row_t probe_rows[24] = '{
		'{8'hff,                 1'b1, 1'b1, 1'b1,
			'{64'h1_0000, 64'h7FFF_FFFE_F000, 1'b1, 1'b0}},
		'{agf_pkg::CHAR_DASH,    1'b0, 1'b1, 1'b0, '0},
		'{8'h00,                 1'b1, 1'b1, 1'b1, '{64'h0, 64'h0, 1'b1, 1'b1}},
		'{"2",                   1'b0, 1'b0, 1'b0, '0},
		'{"0",                   1'b0, 1'b0, 1'b0, '0},
		'{"0",                   1'b0, 1'b0, 1'b0, '0},
		'{"0",                   1'b0, 1'b0, 1'b0, '0},
		'{"0",                   1'b0, 1'b0, 1'b0, '0},
		'{agf_pkg::CHAR_DASH,    1'b0, 1'b1, 1'b1,
			'{64'h1_0000, 64'h1_0000, 1'b0, 1'b0}},
		'{"f",                   1'b0, 1'b0, 1'b0, '0},
		'{agf_pkg::CHAR_DASH,    1'b0, 1'b0, 1'b0, '0},
		'{agf_pkg::CHAR_SPACE,   1'b0, 1'b0, 1'b0, '0},
		'{"z",                   1'b0, 1'b0, 1'b0, '0},
		'{agf_pkg::CHAR_SPACE,   1'b1, 1'b1, 1'b1, '{64'h0, 64'h0, 1'b1, 1'b1}},
		'{"A",                   1'b0, 1'b0, 1'b0, '0},
		'{agf_pkg::CHAR_NEWLINE, 1'b0, 1'b0, 1'b0, '0},
		'{8'hff,                 1'b0, 1'b0, 1'b0, '0},
		'{8'h00,                 1'b0, 1'b0, 1'b0, '0},
		'{agf_pkg::CHAR_DASH,    1'b0, 1'b0, 1'b0, '0},
		'{"1",                   1'b0, 1'b0, 1'b0, '0},
		'{agf_pkg::CHAR_SPACE,   1'b0, 1'b0, 1'b0, '0},
		'{agf_pkg::CHAR_NEWLINE, 1'b0, 1'b0, 1'b0, '0},
		'{"5",                   1'b0, 1'b0, 1'b0, '0},
		'{8'hff,                 1'b1, 1'b0, 1'b0, '0}
	};

	address_map_gap_finder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// value of one address digit; only the low nibble is kept
	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		if (c <= agf_pkg::CHAR_NINE) begin
			d = c - CHAR_ZERO;
		end else begin
			d = c - CHAR_LOWER_A + 8'd10;
		end
		return d[3:0];
	endfunction

	// advance the parser by one beat; returns 1 when a gap is reported
	function automatic bit parse_listing_beat(input logic [7:0] c, input logic eol,
			output agf_pkg::result_t gap);
		logic [63:0] lo;
		logic [63:0] hi;
		bit          hit;
		hit = 1'b0;
		gap = '0;
		lo = (finish_addr > win_low) ? finish_addr : win_low;
		if (eol) begin
			hit = 1'b1;
			gap.final_gap = 1'b1;
			if (scan_phase == SCAN_START) begin
				hi = win_high;
				hit = hi > lo;
				gap.gap_base = lo;
				gap.gap_length = hi - lo;
			end else begin
				gap.malformed = 1'b1;
			end
			scan_phase = SCAN_START;
			start_addr = '0;
			finish_addr = '0;
		end else begin
			case (scan_phase)
				SCAN_START: begin
					if (c == agf_pkg::CHAR_DASH) begin
						hi = (start_addr < win_high) ? start_addr : win_high;
						hit = hi > lo;
						gap.gap_base = lo;
						gap.gap_length = hi - lo;
						start_addr = '0;
						finish_addr = '0;
						scan_phase = SCAN_FINISH;
					end else begin
						start_addr = {start_addr[59:0], digit_value(c)};
					end
				end
				SCAN_FINISH: begin
					if (c == agf_pkg::CHAR_SPACE) begin
						scan_phase = SCAN_SKIP;
					end else begin
						finish_addr = {finish_addr[59:0], digit_value(c)};
					end
				end
				default: begin
					if (c == agf_pkg::CHAR_NEWLINE) begin
						scan_phase = SCAN_START;
					end
				end
			endcase
		end
		return hit;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
		end
	endtask

	// scoreboard: check result beats, predict input beats, track window writes
	always @(posedge clk) begin
		agf_pkg::result_t got;
		agf_pkg::result_t want;
		agf_pkg::result_t pred;
		bit               hit;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.gap_base = m_tdata[63:0];
				got.gap_length = m_tdata[127:64];
				got.final_gap = m_tlast;
				got.malformed = m_tuser[0];
				if (expected_gaps.size() == 0) begin
					report_mismatch("unexpected result", got.gap_base, '0);
				end else begin
					want = expected_gaps.pop_front();
					gaps_checked++;
					if (want.malformed) malformed_seen++;
					if (got.gap_base !== want.gap_base)
						report_mismatch("gap_base", got.gap_base, want.gap_base);
					if (got.gap_length !== want.gap_length)
						report_mismatch("gap_length", got.gap_length, want.gap_length);
					if (got.final_gap !== want.final_gap)
						report_mismatch("final_gap", got.final_gap, want.final_gap);
					if (got.malformed !== want.malformed)
						report_mismatch("malformed", got.malformed, want.malformed);
				end
			end
			if (s_tvalid && s_tready) begin
				hit = parse_listing_beat(s_tdata, s_tlast, pred);
				if (pin_valid) begin
					hit = pin_hit;
					pred = pin_gap;
				end
				if (hit) begin
					expected_gaps.push_back(pred);
					gaps_predicted++;
				end
				beats_accepted++;
			end
			if (cfg_we) begin
				case (cfg_index)
					agf_pkg::REG_WINDOW_LOW:  win_low <= cfg_wdata;
					agf_pkg::REG_WINDOW_HIGH: win_high <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// result side: always ready, coin flips, a fixed pattern, or long stalls
	always @(posedge clk) begin
		pattern_step <= pattern_step + 4'd1;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			case (ready_mode)
				READY_ALWAYS:  m_tready <= 1'b1;
				READY_COIN:    m_tready <= 1'($urandom_range(1, 0));
				READY_PATTERN: m_tready <= (pattern_step[2:0] != 3'd5) && (pattern_step != 4'd2);
				default: begin
					m_tready <= 1'b1;
					if ($urandom_range(15, 0) == 0) stall_left = $urandom_range(24, 4);
				end
			endcase
		end
	end

	// one beat into the block; may leave a random gap after a burst
	task automatic send_beat(input logic [7:0] c, input logic eol,
			input bit pinned = 1'b0, input bit hit = 1'b0,
			input agf_pkg::result_t gap = '0);
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eol;
		pin_valid <= pinned;
		pin_hit <= hit;
		pin_gap <= gap;
		do @(posedge clk); while (!s_tready);
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(gap_max, 1)) @(posedge clk);
				burst_left = $urandom_range(12, 1);
			end else begin
				burst_left--;
			end
		end
	endtask

	// hold the source until every expected gap has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		pin_valid <= 1'b0;
		do @(posedge clk); while (expected_gaps.size() != 0);
	endtask

	task automatic write_window(input logic [agf_pkg::WIN_W-1:0] lo,
			input logic [agf_pkg::WIN_W-1:0] hi);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= agf_pkg::REG_WINDOW_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= agf_pkg::REG_WINDOW_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		windows_used++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? CHAR_ZERO + 8'(n) : CHAR_LOWER_A + 8'(n) - 8'd10;
	endfunction

	function automatic logic [63:0] random_addr(input int shift);
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v >> shift;
	endfunction

	// address in lowercase hex; sometimes padded, sometimes one digit too long
	task automatic emit_hex(input logic [63:0] v);
		int         ndig;
		int         pick;
		logic [3:0] nib;
		ndig = 1;
		for (int i = 1; i < 16; i++) begin
			if ((v >> (4 * i)) != 0) ndig = i + 1;
		end
		pick = $urandom_range(9, 0);
		if (pick == 0) ndig = 16;
		else if (pick == 1) ndig = 17;
		for (int i = ndig - 1; i >= 0; i--) begin
			nib = (i < 16) ? v[4 * i +: 4] : 4'($urandom_range(15, 0));
			send_beat(hex_char(nib), 1'b0);
		end
	endtask

	// a listing of random lines, mostly well formed, ended by the end marker
	task automatic emit_listing(input int lines);
		logic [63:0] cursor;
		logic [63:0] base;
		logic [63:0] top;
		logic [7:0]  c;
		int          shift;
		int          pick;
		shift = $urandom_range(56, 8);
		cursor = random_addr(shift);
		for (int n = 0; n < lines; n++) begin
			pick = $urandom_range(99, 0);
			if (pick < 80) begin
				// regular region line; now and then it overlaps the previous one
				base = ($urandom_range(3, 0) == 0) ? cursor : cursor + random_addr(shift);
				if (pick < 6) base = cursor - random_addr(shift);
				top = base + random_addr(shift) + 64'd1;
				cursor = top;
				emit_hex(base);
				send_beat(agf_pkg::CHAR_DASH, 1'b0);
				emit_hex(top);
				send_beat(agf_pkg::CHAR_SPACE, 1'b0);
				repeat ($urandom_range(4, 0)) begin
					c = 8'($urandom_range(255, 0));
					send_beat((c == agf_pkg::CHAR_NEWLINE) ? CHAR_JUNK : c, 1'b0);
				end
				send_beat(agf_pkg::CHAR_NEWLINE, 1'b0);
			end else if (pick < 88) begin
				// raw noise of any byte value
				repeat ($urandom_range(6, 1)) send_beat(8'($urandom_range(255, 0)), 1'b0);
			end else if (pick < 94) begin
				// uppercase digit and no space: newline lands in the end field
				send_beat(CHAR_UPPER_A + 8'($urandom_range(5, 0)), 1'b0);
				emit_hex(random_addr(shift));
				send_beat(agf_pkg::CHAR_DASH, 1'b0);
				emit_hex(random_addr(shift));
				send_beat(agf_pkg::CHAR_NEWLINE, 1'b0);
			end else begin
				// listing cut off in the middle of a line
				emit_hex(random_addr(shift));
				send_beat(agf_pkg::CHAR_DASH, 1'b0);
				if ($urandom_range(1, 0)) emit_hex(random_addr(shift));
				if ($urandom_range(1, 0)) send_beat(agf_pkg::CHAR_SPACE, 1'b0);
				break;
			end
		end
		send_beat(8'($urandom_range(255, 0)), 1'b1);
		listings_sent++;
	endtask

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// main sequence
	initial begin
		logic [agf_pkg::WIN_W-1:0] lo;
		logic [agf_pkg::WIN_W-1:0] hi;
		int                        phase_end;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = agf_pkg::REG_WINDOW_LOW;
		cfg_wdata = '0;
		pin_valid = 1'b0;
		pin_hit = 1'b0;
		pin_gap = '0;
		win_low = agf_pkg::WINDOW_LOW_RESET;
		win_high = agf_pkg::WINDOW_HIGH_RESET;
		scan_phase = SCAN_START;
		start_addr = '0;
		finish_addr = '0;
		mismatch_count = 0;
		beats_accepted = 0;
		gaps_predicted = 0;
		gaps_checked = 0;
		malformed_seen = 0;
		windows_used = 0;
		listings_sent = 0;
		gap_max = 3;
		burst_left = 0;
		ready_mode = READY_COIN;
		stall_left = 0;
		pattern_step = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under the reset window
		foreach (probe_rows[i]) begin
			send_beat(probe_rows[i].ch, probe_rows[i].eol, probe_rows[i].pinned,
				probe_rows[i].hit, probe_rows[i].gap);
		end

		// random listings, one window setting per phase; beat budget is cumulative
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin lo = '0; hi = '1; end
				1: begin lo = '1; hi = '0; end
				2: begin lo = 64'h1000; hi = 64'h10_0000; end
				3: begin
					lo = random_addr($urandom_range(40, 8));
					hi = lo + random_addr($urandom_range(40, 4));
				end
				4: begin lo = agf_pkg::WINDOW_LOW_RESET; hi = agf_pkg::WINDOW_HIGH_RESET; end
				default: begin
					hi = random_addr($urandom_range(40, 8));
					lo = hi + random_addr($urandom_range(40, 8));
				end
			endcase
			write_window(lo, hi);
			gap_max = (p == 0) ? 0 : $urandom_range(8, 1);
			ready_mode = ready_mode_t'(p % 4);
			phase_end = (RANDOM_BEATS * (p + 1)) / PHASE_COUNT;
			emit_listing($urandom_range(4, 1));
			wait_drained();
			while (beats_accepted < phase_end) emit_listing($urandom_range(4, 1));
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d listing beats in %0d listings over %0d window settings",
			beats_accepted, listings_sent, windows_used);
		$display("%0d gaps compared, %0d of them malformed listings",
			gaps_checked, malformed_seen);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
